FILE: hdl/ccx_pkg.sv
// Package with shared types and constants for the ChaCha20 stream XOR block.
`default_nettype none
package ccx_pkg;
    localparam int unsigned CfgAddrW = 6;
    localparam logic [31:0] Sigma0 = 32'h61707865;
    localparam logic [31:0] Sigma1 = 32'h3320646e;
    localparam logic [31:0] Sigma2 = 32'h79622d32;
    localparam logic [31:0] Sigma3 = 32'h6b206574;
    localparam int unsigned QrSteps = 80;

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_NONCE0 = 3'd4,
        REG_NONCE1 = 3'd5,
        REG_CNT    = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_msg;
        logic init;
        logic step;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic round_done;
        logic need_block;
        logic msg_end;
    } t_status;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
        rotl = (x << s) | (x >> (32 - s));
    endfunction
endpackage
`default_nettype wire

FILE: hdl/ccx_ctrl.sv
// Controller state machine sequencing block generation and byte output.
`default_nettype none
module ccx_ctrl import ccx_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_fire,
    input  wire     i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready
);
    t_state r_state, n_state;
    logic   r_active, n_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_out_free;
                if (i_in_fire) begin
                    o_cmd.load_msg = !r_active;
                    n_active = 1'b1;
                    if (!r_active || i_status.need_block) begin
                        o_cmd.init = 1'b1;
                        n_state    = ST_ROUND;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.step = 1'b1;
                if (i_status.round_done) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
                // The byte after a last byte starts a new message.
                if (i_status.msg_end) begin
                    n_active = 1'b0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/ccx_dp.sv
// Datapath: working words, one quarter round per cycle, keystream and byte XOR.
`default_nettype none
module ccx_dp import ccx_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    input  wire         i_in_fire,
    input  wire  [7:0]  i_data,
    input  wire         i_last,
    input  wire  [63:0] i_key0,
    input  wire  [63:0] i_key1,
    input  wire  [63:0] i_key2,
    input  wire  [63:0] i_key3,
    input  wire  [63:0] i_nonce0,
    input  wire  [31:0] i_nonce1,
    input  wire  [31:0] i_start_cnt,
    output t_status     o_status,
    output logic [7:0]  o_data,
    output logic        o_last
);
    logic [31:0] r_w [16];
    logic [31:0] r_ks [16];
    logic [31:0] init_w [16];
    logic [31:0] r_ctr;
    logic [5:0]  r_off;
    logic        r_need;
    logic [6:0]  r_step;
    logic [7:0]  r_data;
    logic        r_last;
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;
    logic [31:0] ksw;

    always_comb begin
        init_w[0]  = Sigma0;           init_w[1]  = Sigma1;
        init_w[2]  = Sigma2;           init_w[3]  = Sigma3;
        init_w[4]  = i_key0[31:0];     init_w[5]  = i_key0[63:32];
        init_w[6]  = i_key1[31:0];     init_w[7]  = i_key1[63:32];
        init_w[8]  = i_key2[31:0];     init_w[9]  = i_key2[63:32];
        init_w[10] = i_key3[31:0];     init_w[11] = i_key3[63:32];
        // The first block of a message takes the start counter directly.
        init_w[12] = i_cmd.load_msg ? i_start_cnt : r_ctr;
        init_w[13] = i_nonce0[31:0];   init_w[14] = i_nonce0[63:32];
        init_w[15] = i_nonce1;
    end

    // Column rounds use a,a+4,a+8,a+12; diagonal rounds shift rows b, c and d by one, two and three.
    always_comb begin
        logic [1:0] col;
        logic       diag;
        col  = r_step[1:0];
        diag = r_step[2];
        ia = {2'b00, col};
        ib = {2'b01, diag ? col + 2'd1 : col};
        ic = {2'b10, diag ? col + 2'd2 : col};
        id = {2'b11, diag ? col + 2'd3 : col};
        a1 = r_w[ia] + r_w[ib];
        d1 = rotl(r_w[id] ^ a1, 16);
        c1 = r_w[ic] + d1;
        b1 = rotl(r_w[ib] ^ c1, 12);
        a2 = a1 + b1;
        d2 = rotl(d1 ^ a2, 8);
        c2 = c1 + d2;
        b2 = rotl(b1 ^ c2, 7);
    end

    assign o_status = '{round_done: (r_step == 7'(QrSteps - 1)),
                        need_block: r_need,
                        msg_end:    r_last};
    assign ksw = r_ks[r_off[5:2]];

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_data <= i_data;
            r_last <= i_last;
        end
        if (i_cmd.init) begin
            for (int i = 0; i < 16; i++) r_w[i] <= init_w[i];
        end else if (i_cmd.step) begin
            r_w[ia] <= a2; r_w[ib] <= b2; r_w[ic] <= c2; r_w[id] <= d2;
        end
        if (i_cmd.finish) begin
            for (int i = 0; i < 16; i++) r_ks[i] <= r_w[i] + init_w[i];
        end
        if (i_cmd.emit) begin
            o_data <= r_data ^ 8'(ksw >> {r_off[1:0], 3'b000});
            o_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr  <= '0;
            r_off  <= '0;
            r_need <= 1'b1;
            r_step <= '0;
        end else begin
            if (i_cmd.load_msg) r_ctr <= i_start_cnt;
            if (i_cmd.init) r_step <= '0;
            else if (i_cmd.step) r_step <= r_step + 7'd1;
            if (i_cmd.finish) begin
                r_ctr  <= r_ctr + 32'd1;
                r_off  <= '0;
                r_need <= 1'b0;
            end
            if (i_cmd.emit) begin
                if (r_last) begin
                    r_off  <= '0;
                    r_need <= 1'b1;
                end else begin
                    r_off <= r_off + 6'd1;
                    if (r_off == 6'd63) r_need <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: hdl/chacha20_stream_xor.sv
// Top level: ChaCha20 byte stream XOR with APB register port.
// No new byte is taken until the previous one is emitted; the first byte of
// a message and every 64th byte after it also wait for a keystream block
// from a single quarter-round unit that runs the 80 quarter rounds one per
// cycle, then adds the starting words. A result sits in an output register;
// the next byte is taken only once that register is empty or being drained.
`default_nettype none
module chacha20_stream_xor import ccx_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [CfgAddrW-1:0] paddr,
    input  wire  [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [7:0]          s_axis_tdata,  // data_in
    input  wire                 s_axis_tlast,
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [7:0]          m_axis_tdata,  // data_out
    output logic                m_axis_tlast
);
    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nonce0;
    logic [31:0] r_nonce1, r_cnt;
    logic        r_ovalid;
    logic        in_fire, in_ready;
    t_cmd        cmd;
    t_status     status;
    t_reg_idx    widx;

    assign pready = 1'b1;
    assign widx   = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0; r_key3 <= '0;
            r_nonce0 <= '0; r_nonce1 <= '0; r_cnt <= '0;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'b000) begin
            unique case (widx)
                REG_KEY0:   r_key0   <= pwdata;
                REG_KEY1:   r_key1   <= pwdata;
                REG_KEY2:   r_key2   <= pwdata;
                REG_KEY3:   r_key3   <= pwdata;
                REG_NONCE0: r_nonce0 <= pwdata;
                REG_NONCE1: r_nonce1 <= pwdata[31:0];
                REG_CNT:    r_cnt    <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (widx)
            REG_KEY0:   prdata = r_key0;
            REG_KEY1:   prdata = r_key1;
            REG_KEY2:   prdata = r_key2;
            REG_KEY3:   prdata = r_key3;
            REG_NONCE0: prdata = r_nonce0;
            REG_NONCE1: prdata = {32'd0, r_nonce1};
            REG_CNT:    prdata = {32'd0, r_cnt};
            default:    prdata = '0;
        endcase
    end

    // Output slot is free when empty or being drained this cycle.
    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid & in_ready;

    ccx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (!r_ovalid || m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    ccx_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_fire   (in_fire),
        .i_data      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_key0      (r_key0),
        .i_key1      (r_key1),
        .i_key2      (r_key2),
        .i_key3      (r_key3),
        .i_nonce0    (r_nonce0),
        .i_nonce1    (r_nonce1),
        .i_start_cnt (r_cnt),
        .o_status    (status),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (cmd.emit) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
endmodule
`default_nettype wire

FILE: hdl/ccx_chk.sv
// Port-level checker for the ChaCha20 stream XOR block, with its bind.
`default_nettype none
module ccx_chk (
    input wire i_clk,
    input wire i_rst_n,
    input wire s_axis_tvalid,
    input wire s_axis_tready,
    input wire m_axis_tvalid,
    input wire m_axis_tready,
    input wire [7:0] m_axis_tdata,
    input wire m_axis_tlast,
    input wire pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast)) else $error("output changed while stalled");
    a_one_per_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("two transactions accepted back to back");
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind chacha20_stream_xor ccx_chk u_ccx_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);
`default_nettype wire

FILE: tb/chacha20_stream_xor_tb.sv
// Self-checking testbench for the ChaCha20 byte stream XOR block.
`default_nettype none
module chacha20_stream_xor_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ccx_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;  // data_in
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;       // data_out
    logic        m_axis_tlast;

    chacha20_stream_xor dut (.*);

    always #4 i_clk = ~i_clk;

    // Cipher settings and running keystream state as the predictor sees them.
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] counter_start;
    logic [31:0] ks_words [16];
    logic [31:0] blk_count;
    logic [5:0]  blk_offset;
    bit          want_block;
    bit          in_message;

    t_byte_item  pending_bytes [$];
    t_byte_item  expected_out [$];
    int          mismatches = 0;
    bit          quiet_tx = 1'b1;
    bit          quiet_rx = 1'b1;
    bit          send_hold = 1'b0;
    int          rx_hold = 0;

    function automatic logic [31:0] rot32(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void quarter(ref logic [31:0] w [16], input int a, b, c, d);
        w[a] += w[b]; w[d] = rot32(w[d] ^ w[a], 16);
        w[c] += w[d]; w[b] = rot32(w[b] ^ w[c], 12);
        w[a] += w[b]; w[d] = rot32(w[d] ^ w[a], 8);
        w[c] += w[d]; w[b] = rot32(w[b] ^ w[c], 7);
    endfunction

    function automatic void compute_keystream();
        logic [31:0] seed [16];
        logic [31:0] w [16];
        seed[0] = Sigma0; seed[1] = Sigma1; seed[2] = Sigma2; seed[3] = Sigma3;
        for (int k = 0; k < 4; k++) begin
            seed[4 + 2*k] = key_reg[k][31:0];
            seed[5 + 2*k] = key_reg[k][63:32];
        end
        seed[12] = blk_count;
        seed[13] = nonce_lo[31:0];
        seed[14] = nonce_lo[63:32];
        seed[15] = nonce_hi;
        w = seed;
        for (int r = 0; r < 10; r++) begin
            quarter(w, 0, 4, 8, 12); quarter(w, 1, 5, 9, 13);
            quarter(w, 2, 6, 10, 14); quarter(w, 3, 7, 11, 15);
            quarter(w, 0, 5, 10, 15); quarter(w, 1, 6, 11, 12);
            quarter(w, 2, 7, 8, 13); quarter(w, 3, 4, 9, 14);
        end
        for (int k = 0; k < 16; k++) ks_words[k] = w[k] + seed[k];
    endfunction

    function automatic t_byte_item encrypt_byte(t_byte_item in_item);
        t_byte_item res;
        logic [31:0] word;
        if (!in_message) begin
            blk_count = counter_start;
            blk_offset = '0;
            want_block = 1'b1;
            in_message = 1'b1;
        end
        if (want_block) begin
            compute_keystream();
            blk_count += 32'd1;
            blk_offset = '0;
            want_block = 1'b0;
        end
        word = ks_words[blk_offset[5:2]];
        res.data = in_item.data ^ word[8*blk_offset[1:0] +: 8];
        res.last = in_item.last;
        blk_offset += 6'd1;
        if (blk_offset == 0) want_block = 1'b1;
        if (in_item.last) begin
            in_message = 1'b0;
            want_block = 1'b1;
            blk_offset = '0;
        end
        return res;
    endfunction

    function automatic void set_register(t_reg_idx idx, logic [63:0] v);
        case (idx)
            REG_KEY0:   key_reg[0] = v;
            REG_KEY1:   key_reg[1] = v;
            REG_KEY2:   key_reg[2] = v;
            REG_KEY3:   key_reg[3] = v;
            REG_NONCE0: nonce_lo = v;
            REG_NONCE1: nonce_hi = v[31:0];
            REG_CNT:    counter_start = v[31:0];
            default: ;
        endcase
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [63:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 6'(8 * int'(idx)); pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        set_register(idx, v);
    endtask

    // Waits for the block to drain before touching its registers.
    task automatic settle();
        while (pending_bytes.size() != 0 || expected_out.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic program_all(logic [63:0] fill, bit rnd);
        for (int r = int'(REG_KEY0); r <= int'(REG_CNT); r++) begin
            apb_write(t_reg_idx'(r), rnd ? {$urandom, $urandom} : fill);
        end
    endtask

    task automatic queue_message(int len, bit bias);
        t_byte_item it;
        for (int k = 0; k < len; k++) begin
            it.data = bias ? (($urandom_range(0, 1) != 0) ? 8'hff : 8'h00) : 8'($urandom);
            it.last = (k == len - 1);
            pending_bytes.push_back(it);
        end
    endtask

    // Input driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_out.push_back(encrypt_byte({s_axis_tdata, s_axis_tlast}));
                void'(pending_bytes.pop_front());
            end
            if (pending_bytes.size() != 0 && !send_hold &&
                (quiet_tx || $urandom_range(0, 99) >= 16)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_bytes[0].data;
                s_axis_tlast <= pending_bytes[0].last;
            end else if (!(s_axis_tvalid && !s_axis_tready)) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor with a random consumer stall.
    always @(posedge i_clk) begin
        t_byte_item want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output byte %h last %b", m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_out.pop_front();
                    if (want.data !== m_axis_tdata || want.last !== m_axis_tlast) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h/%b, got %h/%b",
                                     want.data, want.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet_rx || $urandom_range(0, 99) >= 16;
            end
        end
    end

    initial begin
        #20ms;
        $display("** chacha20_stream_xor: FAILED **");
        $finish;
    end

    initial begin
        int sent;
        int len;
        key_reg = '{default: '0};
        nonce_lo = '0; nonce_hi = '0; counter_start = '0;
        ks_words = '{default: '0};
        blk_count = '0; blk_offset = '0; want_block = 1'b1; in_message = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all-zero settings (the standard test vector), then extremes.
        queue_message(1, 1'b0);
        queue_message(3, 1'b1);
        settle();
        program_all('1, 1'b0);
        queue_message(10, 1'b1);
        settle();
        // Counter at the top wraps during a two-block message.
        apb_write(REG_CNT, 64'hffff_ffff);
        queue_message(70, 1'b0);
        // A short message straight after, starting again from the same counter.
        queue_message(2, 1'b0);
        settle();

        // Backpressure: consumer stalls while the producer keeps offering.
        rx_hold = 300;
        queue_message(40, 1'b0);
        settle();

        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        sent = 0;
        while (sent < 650) begin
            program_all('0, 1'b1);
            if ($urandom_range(0, 3) == 0) apb_write(REG_CNT, 64'hffff_ffff);
            for (int m = 0; m < 4; m++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140)
                                                  : $urandom_range(1, 40);
                queue_message(len, $urandom_range(0, 5) == 0);
                sent += len;
            end
            // Producer pauses until the output side has caught up.
            if ($urandom_range(0, 3) == 0) begin
                while (pending_bytes.size() != 0) @(posedge i_clk);
                send_hold = 1'b1;
                while (expected_out.size() != 0) @(posedge i_clk);
                send_hold = 1'b0;
            end
            settle();
        end
        program_all('0, 1'b0);
        queue_message(5, 1'b0);
        settle();

        if (mismatches == 0 && expected_out.size() == 0)
            $display("** chacha20_stream_xor: PASSED **");
        else
            $display("** chacha20_stream_xor: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

FILE: chacha20_stream_xor.f
hdl/ccx_pkg.sv
hdl/ccx_ctrl.sv
hdl/ccx_dp.sv
hdl/chacha20_stream_xor.sv
hdl/ccx_chk.sv
tb/chacha20_stream_xor_tb.sv
